### hdl/ppms_pkg.sv
// ----------------------------------------------------------------------------
// Particle motion step package
// Shared types, constants and the arctangent table used by the particle
// motion step pipeline and its rotation and vectoring units.
// ----------------------------------------------------------------------------
package ppms_pkg;

	localparam int TAB_LEN = 24;

	localparam logic [31:0] GAIN_Q30 = 32'd652032874;
	localparam logic [23:0] GAIN_Q24 = 24'd10188014;

	localparam logic [23:0]        SPEED_MAX = 24'hFFFFFF;
	localparam logic signed [23:0] POS_MAX   = 24'sh7FFFFF;
	localparam logic signed [23:0] POS_MIN   = 24'sh800000;

	typedef enum logic [1:0] {
		CFG_FRICTION      = 2'd0,
		CFG_GRAV_HEADING  = 2'd1,
		CFG_GRAV_STRENGTH = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic [15:0]        time_step;
		logic [15:0]        age_ms;
		logic [15:0]        life_ms;
		logic [15:0]        heading_in;
		logic [23:0]        speed_in;
		logic signed [23:0] pos_x_in;
		logic signed [23:0] pos_y_in;
		logic [7:0]         start_alpha;
	} particle_in_t;

	typedef struct packed {
		logic [15:0]        heading_out;
		logic [23:0]        speed_out;
		logic signed [23:0] pos_x_out;
		logic signed [23:0] pos_y_out;
		logic [7:0]         alpha_out;
		logic               is_dead;
	} particle_out_t;

	// Arctangent of 2^-i as a 32-bit binary angle.
	function automatic logic [31:0] atan_entry(input logic [4:0] idx);
		logic [31:0] val;
		case (idx)
			5'd0:    val = 32'd536870912;
			5'd1:    val = 32'd316933406;
			5'd2:    val = 32'd167458907;
			5'd3:    val = 32'd85004756;
			5'd4:    val = 32'd42667331;
			5'd5:    val = 32'd21354465;
			5'd6:    val = 32'd10679838;
			5'd7:    val = 32'd5340245;
			5'd8:    val = 32'd2670163;
			5'd9:    val = 32'd1335087;
			5'd10:   val = 32'd667544;
			5'd11:   val = 32'd333772;
			5'd12:   val = 32'd166886;
			5'd13:   val = 32'd83443;
			5'd14:   val = 32'd41722;
			5'd15:   val = 32'd20861;
			5'd16:   val = 32'd10430;
			5'd17:   val = 32'd5215;
			5'd18:   val = 32'd2608;
			5'd19:   val = 32'd1304;
			5'd20:   val = 32'd652;
			5'd21:   val = 32'd326;
			5'd22:   val = 32'd163;
			5'd23:   val = 32'd81;
			default: val = 32'd0;
		endcase
		return val;
	endfunction

endpackage

### hdl/ppms_stream_if.sv
// ----------------------------------------------------------------------------
// Particle stream interface
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface ppms_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### hdl/ppms_rot.sv
// ----------------------------------------------------------------------------
// Pipelined rotation unit
// Cosine and sine of a 16-bit binary angle in Q24, one stage per iteration,
// with a sideband that travels alongside.
// ----------------------------------------------------------------------------
module ppms_rot #(
	parameter int STEPS  = 16,
	parameter int SIDE_W = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                valid_in,
	input  logic [15:0]         angle,
	input  logic [SIDE_W-1:0]   side_in,
	output logic                valid_out,
	output logic signed [25:0]  cos_out,
	output logic signed [25:0]  sin_out,
	output logic [SIDE_W-1:0]   side_out
);
	logic               v_s    [STEPS+1];
	logic signed [31:0] x_s    [STEPS+1];
	logic signed [31:0] y_s    [STEPS+1];
	logic signed [31:0] z_s    [STEPS+1];
	logic [1:0]         quad_s [STEPS+1];
	logic [SIDE_W-1:0]  side_s [STEPS+1];

	logic [15:0]        shifted;
	logic [1:0]         quad_in;
	logic [15:0]        resid;
	logic signed [31:0] xr;
	logic signed [31:0] yr;

	logic               valid_q;
	logic signed [25:0] cos_q;
	logic signed [25:0] sin_q;
	logic [SIDE_W-1:0]  side_q;

	assign shifted = angle + 16'h2000;
	assign quad_in = shifted[15:14];
	assign resid   = angle - {quad_in, 14'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= signed'(ppms_pkg::GAIN_Q30);
			y_s[0]    <= '0;
			z_s[0]    <= signed'({resid, 16'd0});
			quad_s[0] <= quad_in;
			side_s[0] <= side_in;
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic signed [31:0] dx;
		logic signed [31:0] dy;
		logic signed [31:0] da;

		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;
		assign da = signed'(ppms_pkg::atan_entry(5'(i)));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s[i][31]) begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - da;
				end else begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + da;
				end
				quad_s[i+1] <= quad_s[i];
				side_s[i+1] <= side_s[i];
			end
		end
	end

	always_comb begin
		case (quad_s[STEPS])
			2'd1: begin
				xr = -y_s[STEPS];
				yr = x_s[STEPS];
			end
			2'd2: begin
				xr = -x_s[STEPS];
				yr = -y_s[STEPS];
			end
			2'd3: begin
				xr = y_s[STEPS];
				yr = -x_s[STEPS];
			end
			default: begin
				xr = x_s[STEPS];
				yr = y_s[STEPS];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= v_s[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_q  <= 26'(xr >>> 6);
			sin_q  <= 26'(yr >>> 6);
			side_q <= side_s[STEPS];
		end
	end

	assign valid_out = valid_q;
	assign cos_out   = cos_q;
	assign sin_out   = sin_q;
	assign side_out  = side_q;

endmodule

### hdl/ppms_vec.sv
// ----------------------------------------------------------------------------
// Pipelined vectoring unit
// Angle and scaled magnitude of a vector, one stage per iteration, with a
// sideband that travels alongside.
// ----------------------------------------------------------------------------
module ppms_vec #(
	parameter int STEPS  = 16,
	parameter int SIDE_W = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               valid_in,
	input  logic signed [34:0] a_in,
	input  logic signed [34:0] b_in,
	input  logic [SIDE_W-1:0]  side_in,
	output logic               valid_out,
	output logic [31:0]        angle_out,
	output logic signed [36:0] mag_out,
	output logic [SIDE_W-1:0]  side_out
);
	logic               v_s    [STEPS+1];
	logic signed [36:0] a_s    [STEPS+1];
	logic signed [36:0] b_s    [STEPS+1];
	logic [31:0]        acc_s  [STEPS+1];
	logic [SIDE_W-1:0]  side_s [STEPS+1];

	logic signed [36:0] a_ext;
	logic signed [36:0] b_ext;

	assign a_ext = 37'(a_in);
	assign b_ext = 37'(b_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (a_in[34]) begin
				a_s[0]   <= -a_ext;
				b_s[0]   <= -b_ext;
				acc_s[0] <= 32'h8000_0000;
			end else begin
				a_s[0]   <= a_ext;
				b_s[0]   <= b_ext;
				acc_s[0] <= '0;
			end
			side_s[0] <= side_in;
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic signed [36:0] dx;
		logic signed [36:0] dy;
		logic [31:0]        da;

		assign dx = b_s[i] >>> i;
		assign dy = a_s[i] >>> i;
		assign da = ppms_pkg::atan_entry(5'(i));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!b_s[i][36]) begin
					a_s[i+1]   <= a_s[i] + dx;
					b_s[i+1]   <= b_s[i] - dy;
					acc_s[i+1] <= acc_s[i] + da;
				end else begin
					a_s[i+1]   <= a_s[i] - dx;
					b_s[i+1]   <= b_s[i] + dy;
					acc_s[i+1] <= acc_s[i] - da;
				end
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign valid_out = v_s[STEPS];
	assign angle_out = acc_s[STEPS];
	assign mag_out   = a_s[STEPS];
	assign side_out  = side_s[STEPS];

endmodule

### hdl/particle_polar_motion_step_unit.sv
// ----------------------------------------------------------------------------
// Particle polar motion step unit
// Updates one particle per clock: fades its opacity, applies friction and an
// optional constant gravity vector, and moves it along its heading. The block
// is a single pipeline that accepts a transaction in every cycle while the
// downstream side takes results; most of its depth comes from the three
// chained rotation and vectoring units, one stage per iteration. A stalled
// output holds in the output register while the pipeline keeps filling
// until its last stage is occupied.
// ----------------------------------------------------------------------------
module particle_polar_motion_step_unit #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [1:0]           cfg_index,
	input  logic [23:0]          cfg_data,
	ppms_stream_if.sink          item_in,
	ppms_stream_if.source        item_out
);
	localparam int ALPHA_W    = 8;
	localparam int DIV_PER    = 2;
	localparam int DIV_STAGES = ALPHA_W / DIV_PER;

	typedef struct packed {
		logic [15:0]        dt;
		logic [15:0]        heading;
		logic [23:0]        speed;
		logic signed [25:0] s;
		logic [31:0]        gv;
		logic signed [23:0] px;
		logic signed [23:0] py;
		logic               expired;
		logic [15:0]        life;
		logic [15:0]        rem;
		logic [7:0]         num_lo;
		logic [7:0]         quot;
	} div_item_t;

	typedef struct packed {
		logic [15:0]        dt;
		logic [15:0]        heading;
		logic [23:0]        speed;
		logic signed [25:0] s;
		logic signed [23:0] px;
		logic signed [23:0] py;
		logic               expired;
		logic [7:0]         alpha;
	} r1_side_t;

	typedef struct packed {
		logic [15:0]        heading;
		logic [23:0]        speed;
		logic signed [23:0] px;
		logic signed [23:0] py;
		logic [7:0]         alpha;
		logic               dead;
		logic               move;
		logic [31:0]        vel;
	} r3_side_t;

	logic [23:0] friction_q;
	logic [15:0] grav_heading_q;
	logic [23:0] grav_strength_q;
	logic        grav_on;

	logic advance;
	logic out_take;

	ppms_pkg::particle_in_t in_d;
	logic [15:0]            diff;

	// Stage 1
	logic               v_s1;
	logic [15:0]        dt_s1;
	logic [15:0]        heading_s1;
	logic [15:0]        life_s1;
	logic [23:0]        speed_s1;
	logic signed [23:0] px_s1;
	logic signed [23:0] py_s1;
	logic               expired_s1;
	logic [23:0]        num_s1;
	logic [39:0]        fprod_s1;
	logic [39:0]        gprod_s1;

	// Division stages
	logic      v_d [DIV_STAGES+1];
	div_item_t d_s [DIV_STAGES+1];
	div_item_t d_in;

	// First rotation units
	r1_side_t           r1_side_in;
	r1_side_t           r1_side;
	logic [31:0]        r2_side;
	logic               v_r1;
	logic               v_r2;
	logic signed [25:0] hcos;
	logic signed [25:0] hsin;
	logic signed [25:0] gcos;
	logic signed [25:0] gsin;

	// Stage M1 and M2
	logic               v_m1;
	r1_side_t           side_m1;
	logic signed [51:0] p_hc_m1;
	logic signed [51:0] p_hs_m1;
	logic signed [57:0] p_gc_m1;
	logic signed [57:0] p_gs_m1;
	logic               v_m2;
	r1_side_t           side_m2;
	logic signed [34:0] a_m2;
	logic signed [34:0] b_m2;

	// Vectoring unit
	logic               v_vec;
	logic [31:0]        vec_angle;
	logic signed [36:0] vec_mag;
	r1_side_t           vec_side;

	// Stage G1, G2, G3
	logic               v_g1;
	r1_side_t           side_g1;
	logic [41:0]        pl_g1;
	logic signed [43:0] ph_g1;
	logic [15:0]        hr_g1;
	logic [31:0]        ang_rnd;
	logic signed [18:0] a_hi;

	logic signed [61:0] mprod;
	logic signed [29:0] mag30;
	logic signed [30:0] sv;
	logic [15:0]        heading_nx;
	logic [23:0]        speed_nx;
	logic               dead_nx;
	logic               move_nx;

	logic               v_g2;
	logic [15:0]        heading_g2;
	logic [23:0]        speed_g2;
	logic [15:0]        dt_g2;
	logic signed [23:0] px_g2;
	logic signed [23:0] py_g2;
	logic [7:0]         alpha_g2;
	logic               dead_g2;
	logic               move_g2;

	logic [39:0]        vprod;
	logic               v_g3;
	r3_side_t           side_g3;

	// Final rotation unit and stage P1
	logic               v_r3;
	r3_side_t           r3_side;
	logic signed [25:0] mcos;
	logic signed [25:0] msin;

	logic               v_p1;
	r3_side_t           side_p1;
	logic signed [57:0] pxp_p1;
	logic signed [57:0] pyp_p1;

	logic signed [33:0]     dx;
	logic signed [33:0]     dy;
	logic signed [34:0]     nx;
	logic signed [34:0]     ny;
	ppms_pkg::particle_out_t result;

	logic                    out_valid_q;
	ppms_pkg::particle_out_t out_data_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			friction_q      <= '0;
			grav_heading_q  <= '0;
			grav_strength_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				ppms_pkg::CFG_FRICTION:      friction_q      <= cfg_data;
				ppms_pkg::CFG_GRAV_HEADING:  grav_heading_q  <= cfg_data[15:0];
				ppms_pkg::CFG_GRAV_STRENGTH: grav_strength_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign grav_on = (grav_strength_q != '0);

	assign out_take      = !out_valid_q || item_out.ready;
	assign advance       = out_take || !v_p1;
	assign item_in.ready = advance;

	// Stage 1: lifetime test and the three front multiplications.
	assign in_d = item_in.data;
	assign diff = in_d.life_ms - in_d.age_ms;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (advance) begin
			v_s1 <= item_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			dt_s1      <= in_d.time_step;
			heading_s1 <= in_d.heading_in;
			life_s1    <= in_d.life_ms;
			speed_s1   <= in_d.speed_in;
			px_s1      <= in_d.pos_x_in;
			py_s1      <= in_d.pos_y_in;
			expired_s1 <= (in_d.life_ms == '0) || (in_d.age_ms >= in_d.life_ms);
			num_s1     <= 24'(in_d.start_alpha) * 24'(diff);
			fprod_s1   <= 40'(friction_q) * 40'(in_d.time_step);
			gprod_s1   <= 40'(grav_strength_q) * 40'(in_d.time_step);
		end
	end

	// Stage 2: friction, gravity step and divider setup.
	always_comb begin
		d_in.dt      = dt_s1;
		d_in.heading = heading_s1;
		d_in.speed   = speed_s1;
		d_in.s       = signed'({2'b00, speed_s1}) - signed'({2'b00, fprod_s1[39:16]});
		d_in.gv      = gprod_s1[39:8];
		d_in.px      = px_s1;
		d_in.py      = py_s1;
		d_in.expired = expired_s1;
		d_in.life    = life_s1;
		d_in.rem     = num_s1[23:8];
		d_in.num_lo  = num_s1[7:0];
		d_in.quot    = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_d[0] <= 1'b0;
		end else if (advance) begin
			v_d[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			d_s[0] <= d_in;
		end
	end

	// Opacity division, restoring, two quotient bits per stage.
	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		div_item_t   nxt;
		logic [16:0] t;

		always_comb begin
			nxt = d_s[k];
			t   = '0;
			for (int j = 0; j < DIV_PER; j++) begin
				t          = {nxt.rem, nxt.num_lo[ALPHA_W-1]};
				nxt.num_lo = nxt.num_lo << 1;
				if (t >= {1'b0, nxt.life}) begin
					nxt.rem  = 16'(t - {1'b0, nxt.life});
					nxt.quot = {nxt.quot[ALPHA_W-2:0], 1'b1};
				end else begin
					nxt.rem  = t[15:0];
					nxt.quot = {nxt.quot[ALPHA_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_d[k+1] <= 1'b0;
			end else if (advance) begin
				v_d[k+1] <= v_d[k];
			end
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				d_s[k+1] <= nxt;
			end
		end
	end

	// Heading and gravity direction rotations.
	always_comb begin
		r1_side_in.dt      = d_s[DIV_STAGES].dt;
		r1_side_in.heading = d_s[DIV_STAGES].heading;
		r1_side_in.speed   = d_s[DIV_STAGES].speed;
		r1_side_in.s       = d_s[DIV_STAGES].s;
		r1_side_in.px      = d_s[DIV_STAGES].px;
		r1_side_in.py      = d_s[DIV_STAGES].py;
		r1_side_in.expired = d_s[DIV_STAGES].expired;
		r1_side_in.alpha   = d_s[DIV_STAGES].expired ? '0 : d_s[DIV_STAGES].quot;
	end

	ppms_rot #(
		.STEPS (CORDIC_STEPS),
		.SIDE_W($bits(r1_side_t))
	) u_rot_head (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (advance),
		.valid_in (v_d[DIV_STAGES]),
		.angle    (d_s[DIV_STAGES].heading),
		.side_in  (r1_side_in),
		.valid_out(v_r1),
		.cos_out  (hcos),
		.sin_out  (hsin),
		.side_out (r1_side)
	);

	ppms_rot #(
		.STEPS (CORDIC_STEPS),
		.SIDE_W(32)
	) u_rot_grav (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (advance),
		.valid_in (v_d[DIV_STAGES]),
		.angle    (grav_heading_q),
		.side_in  (d_s[DIV_STAGES].gv),
		.valid_out(v_r2),
		.cos_out  (gcos),
		.sin_out  (gsin),
		.side_out (r2_side)
	);

	// Stage M1: velocity and gravity components.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m1 <= 1'b0;
			v_m2 <= 1'b0;
		end else if (advance) begin
			v_m1 <= v_r1 & v_r2;
			v_m2 <= v_m1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			side_m1 <= r1_side;
			p_hc_m1 <= r1_side.s * hcos;
			p_hs_m1 <= r1_side.s * hsin;
			p_gc_m1 <= signed'({1'b0, r2_side}) * gcos;
			p_gs_m1 <= signed'({1'b0, r2_side}) * gsin;

			side_m2 <= side_m1;
			a_m2    <= 35'(p_hc_m1 >>> 16) + 35'(p_gc_m1 >>> 24);
			b_m2    <= 35'(p_hs_m1 >>> 16) + 35'(p_gs_m1 >>> 24);
		end
	end

	ppms_vec #(
		.STEPS (CORDIC_STEPS),
		.SIDE_W($bits(r1_side_t))
	) u_vec (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (advance),
		.valid_in (v_m2),
		.a_in     (a_m2),
		.b_in     (b_m2),
		.side_in  (side_m2),
		.valid_out(v_vec),
		.angle_out(vec_angle),
		.mag_out  (vec_mag),
		.side_out (vec_side)
	);

	// Stage G1: magnitude gain in two partial products, heading rounding.
	assign ang_rnd = vec_angle + 32'h0000_8000;
	assign a_hi    = vec_mag[36:18];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_g1 <= 1'b0;
			v_g2 <= 1'b0;
			v_g3 <= 1'b0;
		end else if (advance) begin
			v_g1 <= v_vec;
			v_g2 <= v_g1;
			v_g3 <= v_g2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			side_g1 <= vec_side;
			pl_g1   <= 42'(vec_mag[17:0]) * 42'(ppms_pkg::GAIN_Q24);
			ph_g1   <= a_hi * signed'({1'b0, ppms_pkg::GAIN_Q24});
			hr_g1   <= ang_rnd[31:16];
		end
	end

	// Stage G2: final speed, heading and fate of the particle.
	assign mprod = (62'(ph_g1) <<< 18) + signed'(62'(pl_g1));
	assign mag30 = mprod[61:32];

	always_comb begin
		sv         = grav_on ? 31'(mag30) : 31'(side_g1.s);
		heading_nx = side_g1.heading;
		speed_nx   = side_g1.speed;
		dead_nx    = 1'b1;
		move_nx    = 1'b0;
		if (!side_g1.expired) begin
			if (grav_on) begin
				heading_nx = hr_g1;
			end
			if (sv <= 31'sd0) begin
				speed_nx = '0;
			end else begin
				dead_nx  = 1'b0;
				move_nx  = 1'b1;
				speed_nx = (sv > 31'(signed'({1'b0, ppms_pkg::SPEED_MAX}))) ?
				           ppms_pkg::SPEED_MAX : sv[23:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			heading_g2 <= heading_nx;
			speed_g2   <= speed_nx;
			dt_g2      <= side_g1.dt;
			px_g2      <= side_g1.px;
			py_g2      <= side_g1.py;
			alpha_g2   <= side_g1.alpha;
			dead_g2    <= dead_nx;
			move_g2    <= move_nx;
		end
	end

	// Stage G3: distance covered in this frame.
	assign vprod = 40'(speed_g2) * 40'(dt_g2);

	always_ff @(posedge clk) begin
		if (advance) begin
			side_g3.heading <= heading_g2;
			side_g3.speed   <= speed_g2;
			side_g3.px      <= px_g2;
			side_g3.py      <= py_g2;
			side_g3.alpha   <= alpha_g2;
			side_g3.dead    <= dead_g2;
			side_g3.move    <= move_g2;
			side_g3.vel     <= vprod[39:8];
		end
	end

	ppms_rot #(
		.STEPS (CORDIC_STEPS),
		.SIDE_W($bits(r3_side_t))
	) u_rot_move (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (advance),
		.valid_in (v_g3),
		.angle    (side_g3.heading),
		.side_in  (side_g3),
		.valid_out(v_r3),
		.cos_out  (mcos),
		.sin_out  (msin),
		.side_out (r3_side)
	);

	// Stage P1: displacement products.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p1 <= 1'b0;
		end else if (advance) begin
			v_p1 <= v_r3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			side_p1 <= r3_side;
			pxp_p1  <= signed'({1'b0, r3_side.vel}) * mcos;
			pyp_p1  <= signed'({1'b0, r3_side.vel}) * msin;
		end
	end

	// Output stage: rounded displacement and saturated position.
	assign dx = 34'((pxp_p1 + 58'sd8388608) >>> 24);
	assign dy = 34'((pyp_p1 + 58'sd8388608) >>> 24);
	assign nx = 35'(side_p1.px) + 35'(dx);
	assign ny = 35'(side_p1.py) + 35'(dy);

	always_comb begin
		result.heading_out = side_p1.heading;
		result.speed_out   = side_p1.speed;
		result.alpha_out   = side_p1.alpha;
		result.is_dead     = side_p1.dead;
		result.pos_x_out   = side_p1.px;
		result.pos_y_out   = side_p1.py;
		if (side_p1.move) begin
			if (nx > 35'(ppms_pkg::POS_MAX)) begin
				result.pos_x_out = ppms_pkg::POS_MAX;
			end else if (nx < 35'(ppms_pkg::POS_MIN)) begin
				result.pos_x_out = ppms_pkg::POS_MIN;
			end else begin
				result.pos_x_out = nx[23:0];
			end
			if (ny > 35'(ppms_pkg::POS_MAX)) begin
				result.pos_y_out = ppms_pkg::POS_MAX;
			end else if (ny < 35'(ppms_pkg::POS_MIN)) begin
				result.pos_y_out = ppms_pkg::POS_MIN;
			end else begin
				result.pos_y_out = ny[23:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_take) begin
			out_valid_q <= v_p1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_take) begin
			out_data_q <= result;
		end
	end

	assign item_out.valid = out_valid_q;
	assign item_out.data  = out_data_q;

endmodule

### hdl/ppms_checker.sv
// ----------------------------------------------------------------------------
// Particle motion step checker
// Port-level checks on the particle motion step unit, bound to its top level.
// ----------------------------------------------------------------------------
module ppms_checker (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input ppms_pkg::particle_out_t out_data
);

	// A result that is not taken stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn before its transaction completed");

	// A result that is not taken keeps its value.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("result changed while stalled");

	// With the output register empty the pipeline always takes new input.
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while the output register is empty");

	// A particle that is still alive always has a positive speed.
	a_live_speed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.is_dead |-> out_data.speed_out != '0)
		else $error("live particle reported with zero speed");

	// Nothing is accepted while the input valid is low.
	a_idle_input: assert property (@(posedge clk) disable iff (!arst_n)
		!in_valid |-> !(in_valid && in_ready))
		else $error("transaction seen without a valid input");

endmodule

bind particle_polar_motion_step_unit ppms_checker u_ppms_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (item_in.valid),
	.in_ready (item_in.ready),
	.out_valid(item_out.valid),
	.out_ready(item_out.ready),
	.out_data (item_out.data)
);
